// File: rtl/stack_machine_arith_unit_defines.svh
// ----------------------------------------------------------------------------
// stack_machine_arith_unit_defines
// Assertion macros shared by the stack calculator RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_ARITH_UNIT_DEFINES_SVH
`define STACK_MACHINE_ARITH_UNIT_DEFINES_SVH

// Check that holds in the same cycle as its trigger.
`define SMA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds in the cycle after its trigger.
`define SMA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Command codes, error flags, widths and helper functions of the stack calculator.
// ----------------------------------------------------------------------------
package sma_pkg;

    // Field widths.
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int ERR_W  = 4;
    localparam int THR_W  = 17;

    typedef logic [DATA_W-1:0] q16_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [ERR_W-1:0]  err_t;

    // Command codes.
    localparam cmd_t CMD_PUSH = 3'd0;
    localparam cmd_t CMD_POP  = 3'd1;
    localparam cmd_t CMD_ADD  = 3'd2;
    localparam cmd_t CMD_SUB  = 3'd3;
    localparam cmd_t CMD_MUL  = 3'd4;
    localparam cmd_t CMD_DIV  = 3'd5;

    // Error flags.
    localparam err_t ERR_NONE  = 4'b0000;
    localparam err_t ERR_UNDER = 4'b0001;
    localparam err_t ERR_OVER  = 4'b0010;
    localparam err_t ERR_DIVZ  = 4'b0100;
    localparam err_t ERR_UNK   = 4'b1000;

    // Saturation limits.
    localparam q16_t Q_MAX = 32'h7FFF_FFFF;
    localparam q16_t Q_MIN = 32'h8000_0000;

    // Clamp a 33-bit signed sum to the 32-bit range.
    function automatic q16_t sat33(input logic [DATA_W:0] v);
        q16_t r;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r = v[DATA_W] ? Q_MIN : Q_MAX;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Magnitude of a signed value as an unsigned word (most negative maps to 2^31).
    function automatic q16_t abs32(input q16_t v);
        q16_t r;
        if (v[DATA_W-1])
        begin
            r = ~v + q16_t'(1);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/stack_machine_arith_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_arith_unit: Q16.16 stack calculator around one shared add/subtract unit.
// A new beat is accepted only in the idle state, after the previous result has been registered
// for output; that result waits while the output side is stalled. The divider loop runs
// 31 restoring steps, one quotient bit per step.
// Async active-low reset empties the stack, clears the flags and sets zero_threshold to 1.
// ----------------------------------------------------------------------------
`include "stack_machine_arith_unit_defines.svh"

module stack_machine_arith_unit #(
    parameter int STACK_DEPTH = 64,
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1),
    localparam int OUT_BITS = sma_pkg::ERR_W + sma_pkg::DATA_W + DEPTH_W,
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration: zero_threshold.
    input  logic                       cfg_wr_en,
    input  logic [sma_pkg::THR_W-1:0]  cfg_wr_data,
    // Command stream.
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sma_pkg::DATA_W-1:0] s_axis_tdata,   // push_value
    input  logic [sma_pkg::CMD_W-1:0]  s_axis_tuser,   // req_type
    // Result stream.
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [OUT_W-1:0]           m_axis_tdata    // error_mask, result_value, stack_depth
);

    import sma_pkg::*;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = 5;
    localparam logic [CNT_W-1:0] DIV_STEPS = 5'd30;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_POP_LD   = 4'd1;
    localparam logic [3:0] ST_T_LD     = 4'd2;
    localparam logic [3:0] ST_N_LD     = 4'd3;
    localparam logic [3:0] ST_EXEC     = 4'd4;
    localparam logic [3:0] ST_MUL_RND  = 4'd5;
    localparam logic [3:0] ST_DIV_ITER = 4'd6;
    localparam logic [3:0] ST_DIV_SIGN = 4'd7;
    localparam logic [3:0] ST_FINISH   = 4'd8;

    logic [3:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    q16_t               a_reg, a_next;
    q16_t               b_reg, b_next;
    q16_t               res_reg, res_next;
    err_t               fail_reg, fail_next;
    q16_t               rem_reg, rem_next;
    logic [DATA_W-2:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    err_t               err_reg, err_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic               m_valid_reg, m_valid_next;
    err_t               out_err_reg, out_err_next;
    q16_t               out_val_reg, out_val_next;
    logic [DEPTH_W-1:0] out_depth_reg, out_depth_next;

    // Operand store.
    q16_t               mem [STACK_DEPTH];
    q16_t               rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    q16_t               mem_wdata;

    // Shared add/subtract unit.
    logic [DATA_W:0]    alu_a;
    logic [DATA_W:0]    alu_b;
    logic               alu_sub;
    logic [DATA_W+1:0]  alu_sum;

    logic               s_accept;
    logic               out_free;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [DEPTH_W-1:0] depth_p1;
    q16_t               mag_a;
    q16_t               mag_b;
    logic               div_zero;
    logic               div_ovf;
    logic [2*DATA_W-1:0] rnd;
    logic               q_bit;
    logic signed [DATA_W-1:0] a_s;
    logic signed [DATA_W-1:0] b_s;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_depth_reg, out_val_reg, out_err_reg});

    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign depth_m2 = depth_reg - DEPTH_W'(2);
    assign depth_p1 = depth_reg + DEPTH_W'(1);

    // Operand magnitudes and divide checks.
    assign mag_a    = abs32(a_reg);
    assign mag_b    = abs32(b_reg);
    assign div_zero = (mag_b == '0) || ({15'b0, thr_reg} > mag_b);
    assign div_ovf  = ({16'b0, mag_a} >= {1'b0, mag_b, 15'b0});
    assign a_s      = a_reg;
    assign b_s      = b_reg;

    // Product rounding: add one half, the top part then holds the floor.
    assign rnd = prod_reg + 64'd32768;

    // Shared adder; the carry out flags a >= b on subtraction.
    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + {{(DATA_W+1){1'b0}}, alu_sub};
    assign q_bit   = alu_sum[DATA_W+1];

    // Sequencer and commit logic.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        res_next       = res_reg;
        fail_next      = fail_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        depth_next     = depth_reg;
        err_next       = err_reg;
        thr_next       = cfg_wr_en ? cfg_wr_data : thr_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        out_err_next   = out_err_reg;
        out_val_next   = out_val_reg;
        out_depth_next = out_depth_reg;
        mem_we         = 1'b0;
        mem_waddr      = depth_reg[ADDR_W-1:0];
        mem_wdata      = a_reg;
        rd_addr        = depth_m1[ADDR_W-1:0];
        alu_a          = {a_reg[DATA_W-1], a_reg};
        alu_b          = {b_reg[DATA_W-1], b_reg};
        alu_sub        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    cmd_next  = s_axis_tuser;
                    a_next    = s_axis_tdata;
                    res_next  = '0;
                    fail_next = ERR_NONE;
                    unique case (s_axis_tuser) inside
                        CMD_PUSH:
                        begin
                            if (depth_reg >= DEPTH_W'(STACK_DEPTH))
                            begin
                                fail_next = ERR_OVER;
                            end
                            state_next = ST_FINISH;
                        end
                        CMD_POP:
                        begin
                            if (depth_reg == '0)
                            begin
                                fail_next  = ERR_UNDER;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_POP_LD;
                            end
                        end
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        begin
                            if (depth_reg < DEPTH_W'(2))
                            begin
                                fail_next  = ERR_UNDER;
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_T_LD;
                            end
                        end
                        default:
                        begin
                            fail_next  = ERR_UNK;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_POP_LD:
            begin
                res_next   = rd_data_reg;
                state_next = ST_FINISH;
            end

            ST_T_LD:
            begin
                // Top entry has arrived; fetch the next one.
                a_next     = rd_data_reg;
                rd_addr    = depth_m2[ADDR_W-1:0];
                state_next = ST_N_LD;
            end

            ST_N_LD:
            begin
                b_next     = rd_data_reg;
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                unique case (cmd_reg) inside
                    CMD_ADD, CMD_SUB:
                    begin
                        alu_sub    = (cmd_reg == CMD_SUB);
                        res_next   = sat33(alu_sum[DATA_W:0]);
                        state_next = ST_FINISH;
                    end
                    CMD_MUL:
                    begin
                        prod_next  = a_s * b_s;
                        state_next = ST_MUL_RND;
                    end
                    CMD_DIV:
                    begin
                        b_next   = mag_b;
                        neg_next = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];
                        if (div_zero)
                        begin
                            fail_next  = ERR_DIVZ;
                            state_next = ST_FINISH;
                        end
                        else if (div_ovf)
                        begin
                            // Quotient magnitude reaches 2^31: clamp.
                            res_next   = (a_reg[DATA_W-1] ^ b_reg[DATA_W-1]) ? Q_MIN : Q_MAX;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            // Upper quotient bits are known zero; start at bit 30.
                            rem_next   = {15'b0, mag_a[DATA_W-1:15]};
                            quo_next   = {mag_a[14:0], 16'b0};
                            cnt_next   = DIV_STEPS;
                            state_next = ST_DIV_ITER;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end

            ST_MUL_RND:
            begin
                if ((&rnd[63:47]) || !(|rnd[63:47]))
                begin
                    res_next = rnd[47:16];
                end
                else
                begin
                    res_next = rnd[63] ? Q_MIN : Q_MAX;
                end
                state_next = ST_FINISH;
            end

            ST_DIV_ITER:
            begin
                // One restoring step: shift in the next dividend bit, try to subtract.
                alu_a   = {rem_reg, quo_reg[DATA_W-2]};
                alu_b   = {1'b0, b_reg};
                alu_sub = 1'b1;
                if (q_bit)
                begin
                    rem_next = alu_sum[DATA_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-2]};
                end
                quo_next = {quo_reg[DATA_W-3:0], q_bit};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_SIGN;
                end
            end

            ST_DIV_SIGN:
            begin
                alu_a      = '0;
                alu_b      = {2'b0, quo_reg};
                alu_sub    = neg_reg;
                res_next   = alu_sum[DATA_W-1:0];
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    if (fail_reg != ERR_NONE)
                    begin
                        err_next     = err_reg | fail_reg;
                        out_val_next = '0;
                        // A rejected divisor still drops both operands.
                        if (fail_reg == ERR_DIVZ)
                        begin
                            depth_next = depth_m2;
                        end
                    end
                    else
                    begin
                        err_next     = ERR_NONE;
                        out_val_next = res_reg;
                        unique case (cmd_reg) inside
                            CMD_PUSH:
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = depth_reg[ADDR_W-1:0];
                                mem_wdata  = a_reg;
                                depth_next = depth_p1;
                            end
                            CMD_POP:
                            begin
                                depth_next = depth_m1;
                            end
                            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = depth_m2[ADDR_W-1:0];
                                mem_wdata  = res_reg;
                                depth_next = depth_m1;
                            end
                            default:
                            begin
                                depth_next = depth_reg;
                            end
                        endcase
                    end
                    out_err_next   = err_next;
                    out_depth_next = depth_next;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            depth_reg   <= '0;
            err_reg     <= ERR_NONE;
            thr_reg     <= 17'd1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            thr_reg     <= thr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        res_reg       <= res_next;
        fail_reg      <= fail_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cnt_reg       <= cnt_next;
        neg_reg       <= neg_next;
        prod_reg      <= prod_next;
        out_err_reg   <= out_err_next;
        out_val_reg   <= out_val_next;
        out_depth_reg <= out_depth_next;
    end

    // Operand store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Assertions.
    `SMA_ASSERT_NEXT(a_busy_after_accept, s_accept, !s_axis_tready, "accepted beat did not busy the unit")
    `SMA_ASSERT_NOW(a_rem_below_divisor, state_reg == ST_DIV_ITER, rem_reg < b_reg, "divider remainder not below divisor")
    `SMA_ASSERT_NOW(a_fail_zero_value, m_valid_reg && (out_err_reg != ERR_NONE), out_val_reg == '0, "failed command returned a nonzero value")
    `SMA_ASSERT_NOW(a_depth_bound, m_valid_reg, out_depth_reg <= DEPTH_W'(STACK_DEPTH), "reported depth beyond stack size")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: stack_machine_arith_unit testbench
// Sends commands as a stream of beats. A short table covers the corner cases,
// then random command sequences follow under several zero_threshold settings.
// Every result beat is checked field by field against the table's expected result or a local
// model of the operand stack. Both stream sides pause at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sma_pkg::*;

    localparam int STACK_SLOTS = 64;
    localparam int DEPTH_BITS  = 7;
    localparam int RESULT_W    = ((ERR_W + DATA_W + DEPTH_BITS + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 115;

    // Command codes the block does not implement.
    localparam cmd_t CMD_BAD6 = 3'd6;
    localparam cmd_t CMD_BAD7 = 3'd7;

    typedef struct packed {
        err_t                  err;
        q16_t                  value;
        logic [DEPTH_BITS-1:0] depth;
    } stack_result_t;

    typedef struct packed {
        cmd_t          cmd;
        q16_t          operand;
        bit            typed;
        stack_result_t outcome;
    } cmd_row_t;

    localparam stack_result_t NOT_TYPED = '{ERR_NONE, 32'h0, 7'd0};

    // Corner-case commands, run right after reset with zero_threshold at 1.
    localparam int CORNER_ROWS = 28;
    cmd_row_t corner_rows [CORNER_ROWS] = '{
        '{CMD_POP,  32'h0000_0000, 1'b1, '{ERR_UNDER, 32'h0, 7'd0}},
        '{CMD_ADD,  32'h0000_0000, 1'b1, '{ERR_UNDER, 32'h0, 7'd0}},
        '{CMD_BAD6, 32'h0000_0000, 1'b1, '{ERR_UNDER | ERR_UNK, 32'h0, 7'd0}},
        '{CMD_BAD7, 32'hFFFF_FFFF, 1'b1, '{ERR_UNDER | ERR_UNK, 32'h0, 7'd0}},
        '{CMD_PUSH, Q_MAX,         1'b1, '{ERR_NONE, 32'h0, 7'd1}},
        '{CMD_MUL,  32'h0000_0000, 1'b1, '{ERR_UNDER, 32'h0, 7'd1}},
        '{CMD_PUSH, Q_MAX,         1'b1, '{ERR_NONE, 32'h0, 7'd2}},
        '{CMD_ADD,  32'h0000_0000, 1'b1, '{ERR_NONE, Q_MAX, 7'd1}},
        '{CMD_PUSH, Q_MIN,         1'b1, '{ERR_NONE, 32'h0, 7'd2}},
        '{CMD_SUB,  32'h0000_0000, 1'b1, '{ERR_NONE, Q_MIN, 7'd1}},
        '{CMD_PUSH, 32'h0000_0000, 1'b1, '{ERR_NONE, 32'h0, 7'd2}},
        '{CMD_PUSH, 32'h0001_0000, 1'b1, '{ERR_NONE, 32'h0, 7'd3}},
        '{CMD_DIV,  32'h0000_0000, 1'b1, '{ERR_DIVZ, 32'h0, 7'd1}},
        '{CMD_DIV,  32'h0000_0000, 1'b1, '{ERR_DIVZ | ERR_UNDER, 32'h0, 7'd1}},
        '{CMD_POP,  32'h0000_0000, 1'b1, '{ERR_NONE, Q_MIN, 7'd0}},
        '{CMD_PUSH, 32'hFFFE_0000, 1'b1, '{ERR_NONE, 32'h0, 7'd1}},
        '{CMD_PUSH, Q_MAX,         1'b1, '{ERR_NONE, 32'h0, 7'd2}},
        '{CMD_MUL,  32'h0000_0000, 1'b1, '{ERR_NONE, Q_MIN, 7'd1}},
        '{CMD_PUSH, 32'h0000_0001, 1'b0, NOT_TYPED},
        '{CMD_PUSH, 32'h0000_8000, 1'b0, NOT_TYPED},
        '{CMD_MUL,  32'h0000_0000, 1'b0, NOT_TYPED},
        '{CMD_PUSH, 32'hFFFF_8000, 1'b0, NOT_TYPED},
        '{CMD_MUL,  32'h0000_0000, 1'b0, NOT_TYPED},
        '{CMD_PUSH, 32'h0000_0001, 1'b0, NOT_TYPED},
        '{CMD_PUSH, Q_MAX,         1'b0, NOT_TYPED},
        '{CMD_DIV,  32'h0000_0000, 1'b0, NOT_TYPED},
        '{CMD_ADD,  32'h0000_0000, 1'b0, NOT_TYPED},
        '{CMD_DIV,  32'h0000_0000, 1'b0, NOT_TYPED}
    };

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [THR_W-1:0]    cfg_wr_data   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata  = '0;   // push_value
    logic [CMD_W-1:0]    s_axis_tuser  = '0;   // req_type
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] m_axis_tdata;         // error_mask, result_value, stack_depth

    // Local model of the operand stack and its settings.
    q16_t             operand_mem [STACK_SLOTS];
    int               stack_count  = 0;
    err_t             sticky_flags = ERR_NONE;
    logic [THR_W-1:0] zero_limit   = 17'd1;

    stack_result_t pending_results [$];
    bit            mismatch_seen = 1'b0;

    // Sender pacing.
    int burst_left = 0;
    bit tx_no_gaps = 1'b0;

    // Receiver pacing.
    int         rx_mode  = 0;
    int         rx_hold  = 0;
    logic [7:0] rx_cycle = '0;

    stack_machine_arith_unit #(
        .STACK_DEPTH (STACK_SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Clamp a wide signed value to the Q16.16 range.
    function automatic q16_t clamp_q16(input longint v);
        q16_t r;
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            r = Q_MAX;
        end
        else if (v < -longint'(64'h8000_0000))
        begin
            r = Q_MIN;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Execute one command on the local stack and return the result beat it causes.
    function automatic stack_result_t execute_command(input cmd_t cmd, input q16_t operand);
        stack_result_t r;
        err_t          fail;
        q16_t          value;
        longint        top_v;
        longint        next_v;
        longint        mag;
        longint        wide;
        fail  = ERR_NONE;
        value = '0;
        wide  = 0;
        case (cmd)
            CMD_PUSH:
            begin
                if (stack_count >= STACK_SLOTS)
                begin
                    fail = ERR_OVER;
                end
                else
                begin
                    operand_mem[stack_count] = operand;
                    stack_count++;
                end
            end
            CMD_POP:
            begin
                if (stack_count < 1)
                begin
                    fail = ERR_UNDER;
                end
                else
                begin
                    stack_count--;
                    value = operand_mem[stack_count];
                end
            end
            CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
            begin
                if (stack_count < 2)
                begin
                    fail = ERR_UNDER;
                end
                else
                begin
                    top_v  = $signed(operand_mem[stack_count-1]);
                    next_v = $signed(operand_mem[stack_count-2]);
                    stack_count -= 2;
                    if (cmd == CMD_ADD)
                    begin
                        wide = top_v + next_v;
                    end
                    else if (cmd == CMD_SUB)
                    begin
                        wide = top_v - next_v;
                    end
                    else if (cmd == CMD_MUL)
                    begin
                        // Round to nearest, ties toward plus infinity.
                        wide = (top_v * next_v + 64'sd32768) >>> 16;
                    end
                    else
                    begin
                        mag = (next_v < 0) ? -next_v : next_v;
                        if (next_v == 0 || mag < longint'(zero_limit))
                        begin
                            fail = ERR_DIVZ;
                        end
                        else
                        begin
                            wide = (top_v * 64'sd65536) / next_v;
                        end
                    end
                    if (fail == ERR_NONE)
                    begin
                        value = clamp_q16(wide);
                        operand_mem[stack_count] = value;
                        stack_count++;
                    end
                end
            end
            default:
            begin
                fail = ERR_UNK;
            end
        endcase
        sticky_flags = (fail != ERR_NONE) ? (sticky_flags | fail) : ERR_NONE;
        r.err   = sticky_flags;
        r.value = (fail != ERR_NONE || cmd == CMD_PUSH) ? q16_t'(0) : value;
        r.depth = DEPTH_BITS'(stack_count);
        return r;
    endfunction

    // Operand mix: extremes, small numbers, values around the zero threshold, raw bits.
    function automatic q16_t pick_operand();
        q16_t r;
        int   sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            case ($urandom_range(0, 6))
                0: r = Q_MAX;
                1: r = Q_MIN;
                2: r = 32'h0000_0000;
                3: r = 32'h0000_0001;
                4: r = 32'hFFFF_FFFF;
                5: r = 32'h0001_0000;
                default: r = 32'hFFFF_0000;
            endcase
        end
        else if (sel <= 3)
        begin
            r = q16_t'(int'($urandom_range(0, 8 * 65536)) - 4 * 65536);
        end
        else if (sel == 4)
        begin
            r = q16_t'(int'($urandom_range(0, 2 * int'(zero_limit) + 4)) - int'(zero_limit) - 2);
        end
        else
        begin
            r = $urandom;
        end
        return r;
    endfunction

    // Command mix for ordinary random traffic.
    function automatic cmd_t pick_command();
        cmd_t r;
        int   roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
        begin
            r = CMD_PUSH;
        end
        else if (roll < 55)
        begin
            r = CMD_POP;
        end
        else if (roll < 64)
        begin
            r = CMD_ADD;
        end
        else if (roll < 73)
        begin
            r = CMD_SUB;
        end
        else if (roll < 83)
        begin
            r = CMD_MUL;
        end
        else if (roll < 96)
        begin
            r = CMD_DIV;
        end
        else
        begin
            r = (roll[0]) ? CMD_BAD7 : CMD_BAD6;
        end
        return r;
    endfunction

    // Send one command beat, pausing between bursts, and record what it should return.
    task automatic send_command(input cmd_t cmd, input q16_t operand, input bit typed,
                                input stack_result_t typed_outcome);
        int            gap;
        stack_result_t predicted;
        if (burst_left == 0)
        begin
            gap = 0;
            if (!tx_no_gaps)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
            end
            if (gap != 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= operand;
        s_axis_tuser  <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predicted = execute_command(cmd, operand);
        pending_results.push_back(typed ? typed_outcome : predicted);
    endtask

    // Stop sending and wait until every result beat has come back.
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write zero_threshold while the block is idle.
    task automatic write_threshold(input logic [THR_W-1:0] thr);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        zero_limit = thr;
    endtask

    // Receiver: switches between always ready, short random stalls and long stalls.
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_cycle == 8'd0)
        begin
            rx_mode <= $urandom_range(0, 2);
        end
        if (rx_hold != 0)
        begin
            rx_hold <= rx_hold - 1;
        end
        else if (rx_mode == 0)
        begin
            m_axis_tready <= 1'b1;
        end
        else if (rx_mode == 1)
        begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
            rx_hold       <= $urandom_range(0, 2);
        end
        else if (m_axis_tready)
        begin
            m_axis_tready <= 1'b0;
            rx_hold       <= $urandom_range(4, 30);
        end
        else
        begin
            m_axis_tready <= 1'b1;
            rx_hold       <= $urandom_range(0, 3);
        end
    end

    // Compare every accepted result beat with the oldest pending result.
    always @(posedge clk)
    begin
        stack_result_t want;
        stack_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[ERR_W+DATA_W+DEPTH_BITS-1:0];
            got.err   = m_axis_tdata[ERR_W-1:0];
            got.value = m_axis_tdata[ERR_W+DATA_W-1:ERR_W];
            got.depth = m_axis_tdata[ERR_W+DATA_W+DEPTH_BITS-1:ERR_W+DATA_W];
            if (pending_results.size() == 0)
            begin
                $error("result beat with no command pending: %h", m_axis_tdata);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.err !== want.err)
                begin
                    $error("error_mask: expected %h, got %h", want.err, got.err);
                    mismatch_seen = 1'b1;
                end
                if (got.value !== want.value)
                begin
                    $error("result_value: expected %h, got %h", want.value, got.value);
                    mismatch_seen = 1'b1;
                end
                if (got.depth !== want.depth)
                begin
                    $error("stack_depth: expected %0d, got %0d", want.depth, got.depth);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // Stimulus: corner cases, then random phases under several thresholds.
    initial
    begin
        logic [THR_W-1:0] phase_thr [6];
        bit               climbing;
        int               spill_left;
        cmd_t             cmd;
        phase_thr[0] = 17'd0;
        phase_thr[1] = 17'd65536;
        phase_thr[2] = 17'd131071;
        phase_thr[3] = THR_W'($urandom_range(0, 65536));
        phase_thr[4] = 17'd1;
        phase_thr[5] = THR_W'($urandom_range(0, 16));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < CORNER_ROWS; i++)
        begin
            send_command(corner_rows[i].cmd, corner_rows[i].operand, corner_rows[i].typed,
                         corner_rows[i].outcome);
        end

        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            write_threshold(phase_thr[p]);
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            climbing   = $urandom_range(0, 1);
            spill_left = $urandom_range(1, 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Climbing fills the stack and pushes past the top a few times.
                if (!climbing && $urandom_range(0, 149) == 0)
                begin
                    climbing   = 1'b1;
                    spill_left = $urandom_range(1, 3);
                end
                if (climbing)
                begin
                    cmd = ($urandom_range(0, 19) == 0) ? pick_command() : CMD_PUSH;
                    if (stack_count >= STACK_SLOTS)
                    begin
                        cmd = CMD_PUSH;
                        spill_left--;
                        if (spill_left == 0)
                        begin
                            climbing = 1'b0;
                        end
                    end
                end
                else
                begin
                    cmd = pick_command();
                end
                send_command(cmd, pick_operand(), 1'b0, NOT_TYPED);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (!mismatch_seen)
        begin
            $display("stack_machine_arith_unit test passed");
        end
        else
        begin
            $display("stack_machine_arith_unit test failed");
        end
        $finish;
    end

    // Watchdog against a stuck handshake.
    initial
    begin
        #10_000_000;
        $display("stack_machine_arith_unit test failed");
        $finish;
    end

endmodule
